// ===== design/pli_pkg.sv =====
// Shared types and constants for the piecewise linear interpolator.
`default_nettype none

package pli_pkg;

    localparam int DATA_W  = 32;
    localparam int ENTRY_W = 2 * DATA_W;

    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_CLAMP  = 2'd1,
        ST_FEW    = 2'd2,
        ST_NOSEG  = 2'd3
    } t_status;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== design/pli_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/piecewise_linear_interpolator_top.sv =====
// Top level of the piecewise linear interpolator: breakpoint table, segment scan, mul/div.
// A write item causes no result; the next item can be taken in the next cycle.
// A query with fewer than two points delivers its result without reading the table; a clamp
// at the first point is found in S_RD0, a clamp at the last point in S_RDL. An interpolated
// query does one RAM read per scanned entry (n points in use), a multiply in S_MUL and
// S_MADD and a bit-serial divide over the 64-bit product. One query is worked on at a time.
// Synchronous active-low reset clears control state and num_points; the table is undefined.
`default_nettype none

module piecewise_linear_interpolator_top #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [4:0]            i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_command,
    input  wire logic [3:0]            i_point_index,
    input  wire logic signed [31:0]    i_point_x,
    input  wire logic signed [31:0]    i_point_y,
    input  wire logic signed [31:0]    i_query_x,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [31:0]         o_result_y,
    output pli_pkg::t_status           o_status
);

    import pli_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int IW   = (AW > 4) ? AW : 4;
    localparam int CW   = (AW > 5) ? AW : 5;
    localparam int NCAP = (MAX_POINTS > 31) ? 31 : MAX_POINTS;
    localparam logic [31:0]        FEW_Y  = 32'hFFFF_FFFF << FRAC_BITS;
    localparam logic signed [33:0] SAT_HI = 34'sh07FFFFFFF;
    localparam logic signed [33:0] SAT_LO = -34'sh080000000;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RD0  = 9'b000000010,
        S_RDL  = 9'b000000100,
        S_SCAN = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_MADD = 9'b000100000,
        S_DIV  = 9'b001000000,
        S_FIN  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [4:0] r_num_points;

    logic signed [31:0] r_qx, n_qx;
    logic signed [31:0] r_x1, n_x1;
    logic signed [31:0] r_y1, n_y1;
    logic               r_dy_neg, n_dy_neg;
    logic [32:0]        r_dy_mag, n_dy_mag;
    logic [31:0]        r_dx, n_dx;
    logic [31:0]        r_t, n_t;
    logic [63:0]        r_prod, n_prod;
    logic [31:0]        r_rem, n_rem;
    logic [5:0]         r_div_cnt, n_div_cnt;
    logic [CW-1:0]      r_idx, n_idx;
    logic [31:0]        r_res_y, n_res_y;
    t_status            r_res_st, n_res_st;

    logic               r_out_valid, n_out_valid;
    logic signed [31:0] r_result_y, n_result_y;
    t_status            r_status, n_status;

    // table port
    logic               ram_we;
    logic [IW-1:0]      widx;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic signed [31:0] rd_x, rd_y;

    logic [4:0]         n_eff;
    logic [CW-1:0]      last_idx;
    logic [CW-1:0]      idx_inc;
    logic               in_acc;
    logic               out_free;

    // datapath temporaries
    logic signed [32:0] dx33, t33, dy33;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic [32:0]        rem_diff;
    logic signed [33:0] y1_34, q34, sum34;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_result_y  = r_result_y;
    assign o_status    = r_status;

    assign n_eff    = (int'(r_num_points) > NCAP) ? 5'(NCAP) : r_num_points;
    assign last_idx = CW'(n_eff - 5'd1);
    assign idx_inc  = r_idx + 1'b1;

    assign widx   = IW'(i_point_index);
    assign ram_we = in_acc && (i_command == CMD_WRITE) && (int'(i_point_index) < MAX_POINTS);

    assign rd_x = ram_rdata[ENTRY_W-1:DATA_W];
    assign rd_y = ram_rdata[DATA_W-1:0];

    always_comb begin
        unique case (r_state)
            S_RD0:   ram_raddr = last_idx[AW-1:0];
            S_RDL:   ram_raddr = AW'(1);
            S_SCAN:  ram_raddr = idx_inc[AW-1:0];
            default: ram_raddr = '0;
        endcase
    end

    pli_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (widx[AW-1:0]),
        .i_wdata ({i_point_x, i_point_y}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign dx33 = {rd_x[31], rd_x} - {r_x1[31], r_x1};
    assign t33  = {r_qx[31], r_qx} - {r_x1[31], r_x1};
    assign dy33 = {rd_y[31], rd_y} - {r_y1[31], r_y1};

    assign rem_sh   = {r_rem, r_prod[63]};
    assign rem_ge   = rem_sh >= {1'b0, r_dx};
    assign rem_diff = rem_sh - {1'b0, r_dx};

    assign y1_34 = {{2{r_y1[31]}}, r_y1};
    assign q34   = {1'b0, r_prod[32:0]};
    assign sum34 = r_dy_neg ? (y1_34 - q34) : (y1_34 + q34);

    always_comb begin
        n_state     = r_state;
        n_qx        = r_qx;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_dy_neg    = r_dy_neg;
        n_dy_mag    = r_dy_mag;
        n_dx        = r_dx;
        n_t         = r_t;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_div_cnt   = r_div_cnt;
        n_idx       = r_idx;
        n_res_y     = r_res_y;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && !i_out_ready;
        n_result_y  = r_result_y;
        n_status    = r_status;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_command == CMD_QUERY)) begin
                    n_qx = i_query_x;
                    if (n_eff < 5'd2) begin
                        n_res_y  = FEW_Y;
                        n_res_st = ST_FEW;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_RD0;
                    end
                end
            end
            S_RD0: begin
                n_x1 = rd_x;
                n_y1 = rd_y;
                if (r_qx <= rd_x) begin
                    n_res_y  = rd_y;
                    n_res_st = ST_CLAMP;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_RDL;
                end
            end
            S_RDL: begin
                if (r_qx >= rd_x) begin
                    n_res_y  = rd_y;
                    n_res_st = ST_CLAMP;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = CW'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // rd_* holds entry r_idx, r_x1/r_y1 entry r_idx-1
                if ((r_x1 <= r_qx) && (r_qx <= rd_x)) begin
                    n_dy_neg = dy33[32];
                    n_dy_mag = dy33[32] ? 33'(-dy33) : 33'(dy33);
                    n_dx     = dx33[31:0];
                    n_t      = t33[31:0];
                    if (dx33 == '0) begin
                        n_res_y  = r_y1;
                        n_res_st = ST_INTERP;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end else if (r_idx == last_idx) begin
                    n_res_y  = '0;
                    n_res_st = ST_NOSEG;
                    n_state  = S_DONE;
                end else begin
                    n_x1  = rd_x;
                    n_y1  = rd_y;
                    n_idx = idx_inc;
                end
            end
            S_MUL: begin
                n_prod  = r_dy_mag[31:0] * r_t;
                n_state = S_MADD;
            end
            S_MADD: begin
                // |dy| <= 2^32 and t < 2^32, so the product fits 64 bits
                if (r_dy_mag[32]) begin
                    n_prod = r_prod + {r_t, 32'h0};
                end
                n_rem     = '0;
                n_div_cnt = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                n_rem     = rem_ge ? rem_diff[31:0] : rem_sh[31:0];
                n_prod    = {r_prod[62:0], rem_ge};
                n_div_cnt = r_div_cnt + 6'd1;
                if (r_div_cnt == 6'd63) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (sum34 > SAT_HI) begin
                    n_res_y = 32'h7FFF_FFFF;
                end else if (sum34 < SAT_LO) begin
                    n_res_y = 32'h8000_0000;
                end else begin
                    n_res_y = sum34[31:0];
                end
                n_res_st = ST_INTERP;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_result_y  = r_res_y;
                    n_status    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_num_points <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_num_points <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_qx       <= n_qx;
        r_x1       <= n_x1;
        r_y1       <= n_y1;
        r_dy_neg   <= n_dy_neg;
        r_dy_mag   <= n_dy_mag;
        r_dx       <= n_dx;
        r_t        <= n_t;
        r_prod     <= n_prod;
        r_rem      <= n_rem;
        r_div_cnt  <= n_div_cnt;
        r_idx      <= n_idx;
        r_res_y    <= n_res_y;
        r_res_st   <= n_res_st;
        r_result_y <= n_result_y;
        r_status   <= n_status;
    end

    a_write_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE))
        else $error("table written while a query is in flight");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dx != '0))
        else $error("divider running with zero divisor");

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_prod[63:33] == '0))
        else $error("quotient exceeds segment height");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && out_free) |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("finished item not moved to output");

endmodule

`default_nettype wire
